/* hw/rtl/crc32_direct_msb_checksum_unit_assert.svh */
// Assertion macros shared by the checksum unit RTL.
`ifndef CRC32_DIRECT_MSB_CHECKSUM_UNIT_ASSERT_SVH
`define CRC32_DIRECT_MSB_CHECKSUM_UNIT_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define CRC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle check");

// Next-cycle implication, disabled in reset.
`define CRC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle check");

`endif

/* hw/rtl/crc32dm_pkg.sv */
// Types, constants and CRC table function for the checksum unit.
`default_nettype none
package crc32dm_pkg;

   localparam int CRC_WIDTH = 32;
   localparam int BYTE_WIDTH = 8;
   localparam int COUNT_WIDTH = 3;
   localparam logic [CRC_WIDTH-1:0] CRC_POLY = 32'h04C11DB7;
   localparam logic [COUNT_WIDTH-1:0] LOAD_BYTES = 3'd4;

   typedef struct packed {
      logic [BYTE_WIDTH-1:0] data_byte;
      logic                  first_of_message;
      logic                  last_of_message;
   } item_type;

   typedef struct packed {
      logic                 valid;
      logic [CRC_WIDTH-1:0] checksum;
      logic                 too_short;
   } result_type;

   // Table entry for the MSB-first step: top byte pushed through 8 shifts.
   function automatic logic [CRC_WIDTH-1:0] table_entry(input logic [BYTE_WIDTH-1:0] idx);
      logic [CRC_WIDTH-1:0] v;
      v = {idx, {(CRC_WIDTH-BYTE_WIDTH){1'b0}}};
      for (int k = 0; k < BYTE_WIDTH; k++) begin
         if (v[CRC_WIDTH-1]) begin
            v = {v[CRC_WIDTH-2:0], 1'b0} ^ CRC_POLY;
         end else begin
            v = {v[CRC_WIDTH-2:0], 1'b0};
         end
      end
      return v;
   endfunction

endpackage
`default_nettype wire

/* hw/rtl/crc32dm_step.sv */
// CRC state registers and the one-byte update step.
`default_nettype none
module crc32dm_step (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    item_fire,
   input  crc32dm_pkg::item_type   item,
   output crc32dm_pkg::result_type result
);
   import crc32dm_pkg::*;

   logic [CRC_WIDTH-1:0]   crc_ff, crc_in;
   logic [COUNT_WIDTH-1:0] bytes_seen_ff, bytes_seen_in;

   logic [CRC_WIDTH-1:0]   crc_base;
   logic [COUNT_WIDTH-1:0] cnt_base;
   logic [CRC_WIDTH-1:0]   shifted;
   logic [CRC_WIDTH-1:0]   crc_step;
   logic [COUNT_WIDTH-1:0] cnt_step;
   logic                   short_msg;

   always_comb begin
      // first flag drops any message in progress
      crc_base = item.first_of_message ? '0 : crc_ff;
      cnt_base = item.first_of_message ? '0 : bytes_seen_ff;
      shifted  = {crc_base[CRC_WIDTH-BYTE_WIDTH-1:0], item.data_byte};

      if (cnt_base < LOAD_BYTES) begin
         cnt_step = cnt_base + COUNT_WIDTH'(1);
         crc_step = (cnt_step == LOAD_BYTES) ? ~shifted : shifted;
      end else begin
         cnt_step = cnt_base;
         crc_step = table_entry(crc_base[CRC_WIDTH-1 -: BYTE_WIDTH]) ^ shifted;
      end

      short_msg = (cnt_step < LOAD_BYTES);

      result.valid     = item_fire && item.last_of_message;
      result.too_short = short_msg;
      result.checksum  = short_msg ? '0 : ~crc_step;

      crc_in        = crc_ff;
      bytes_seen_in = bytes_seen_ff;
      if (item_fire) begin
         if (item.last_of_message) begin
            crc_in        = '0;
            bytes_seen_in = '0;
         end else begin
            crc_in        = crc_step;
            bytes_seen_in = cnt_step;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff        <= '0;
         bytes_seen_ff <= '0;
      end else begin
         crc_ff        <= crc_in;
         bytes_seen_ff <= bytes_seen_in;
      end
   end

`include "crc32_direct_msb_checksum_unit_assert.svh"

   `CRC_ASSERT_NEXT(a_clear_after_last, clock, reset, item_fire && item.last_of_message, crc_ff == '0 && bytes_seen_ff == '0)
   `CRC_ASSERT_NOW(a_short_is_zero, clock, reset, result.valid && result.too_short, result.checksum == '0)
   `CRC_ASSERT_NEXT(a_load_counts, clock, reset, item_fire && !item.first_of_message && !item.last_of_message && bytes_seen_ff < LOAD_BYTES, bytes_seen_ff == $past(bytes_seen_ff) + COUNT_WIDTH'(1))
   `CRC_ASSERT_NOW(a_count_saturates, clock, reset, 1'b1, bytes_seen_ff <= LOAD_BYTES)

endmodule
`default_nettype wire

/* hw/rtl/crc32dm_out.sv */
// Result output register for the checksum unit.
`default_nettype none
module crc32dm_out (
   input  logic                    clock,
   input  logic                    reset,
   input  crc32dm_pkg::result_type result,
   output logic                    out_free,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [31:0]             rsp_tdata,
   output logic                    rsp_tuser
);
   import crc32dm_pkg::*;

   logic                 valid_ff, valid_in;
   logic [CRC_WIDTH-1:0] checksum_ff, checksum_in;
   logic                 short_ff, short_in;

   always_comb begin
      out_free    = !valid_ff || rsp_tready;
      valid_in    = result.valid ? 1'b1 : (rsp_tready ? 1'b0 : valid_ff);
      checksum_in = result.valid ? result.checksum : checksum_ff;
      short_in    = result.valid ? result.too_short : short_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      checksum_ff <= checksum_in;
      short_ff    <= short_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = checksum_ff;
   assign rsp_tuser  = short_ff;

endmodule
`default_nettype wire

/* hw/rtl/crc32_direct_msb_checksum_unit.sv */
// Top level of the streaming CRC-32 (poly 04C11DB7, MSB first) checksum unit.
//
//  channel  dir  word                      handshake
//  req_     in   data byte + first + last  req_tvalid / req_tready
//  rsp_     out  checksum + too_short      rsp_tvalid / rsp_tready
//
// One byte per cycle sustained unless a final byte waits for the result register:
// input register -> step logic -> result register, which drives rsp_tvalid.
// The first four bytes of a message are shifted in directly, then inverted.
// Later byte steps are one table lookup (eight XOR shifts on the top byte) and an XOR.
// Reset clears the CRC register, byte count and both valid flags.
// Non-final bytes never wait in the input register; a final byte waits there only
// while the result register holds an untaken word.
`default_nettype none
module crc32_direct_msb_checksum_unit (
   input  logic        clock,
   input  logic        reset,
   // input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] first_of_message
   input  logic        req_tlast,   // last_of_message
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] checksum
   output logic        rsp_tuser    // [0] too_short
);
   import crc32dm_pkg::*;

   // input register
   logic     s1_valid_ff, s1_valid_in;
   item_type s1_item_ff, s1_item_in;

   logic       req_fire;
   logic       s1_go;
   logic       out_free;
   result_type result;

   always_comb begin
      // a final byte needs room in the result register
      s1_go      = s1_valid_ff && (!s1_item_ff.last_of_message || out_free);
      req_tready = !s1_valid_ff || s1_go;
      req_fire   = req_tvalid && req_tready;

      s1_valid_in = req_fire ? 1'b1 : (s1_go ? 1'b0 : s1_valid_ff);
      s1_item_in  = s1_item_ff;
      if (req_fire) begin
         s1_item_in.data_byte        = req_tdata;
         s1_item_in.first_of_message = req_tuser;
         s1_item_in.last_of_message  = req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      s1_item_ff <= s1_item_in;
   end

   crc32dm_step u_step (
      .clock     (clock),
      .reset     (reset),
      .item_fire (s1_go),
      .item      (s1_item_ff),
      .result    (result)
   );

   crc32dm_out u_out (
      .clock      (clock),
      .reset      (reset),
      .result     (result),
      .out_free   (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

`include "crc32_direct_msb_checksum_unit_assert.svh"

   `CRC_ASSERT_NOW(a_no_overwrite_in, clock, reset, s1_valid_ff && !s1_go, !req_tready)
   `CRC_ASSERT_NOW(a_no_result_drop, clock, reset, result.valid, out_free)
   `CRC_ASSERT_NEXT(a_result_follows, clock, reset, result.valid, rsp_tvalid)

endmodule
`default_nettype wire
